// ----- rtl/core/evm_pkg.sv -----
// Shared constants and types for the segment metrics pipeline.
package evm_pkg;

  localparam int CoordBitsDef = 32;
  localparam int CordicSteps  = 32;
  localparam int CordicW      = 62;
  localparam int AngW         = 34;
  localparam int PctCapW      = 41;

  localparam logic [31:0] ATAN_TAB [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [2:0] {
    SEC_N, SEC_NE, SEC_E, SEC_SE, SEC_S, SEC_SW, SEC_W, SEC_NW
  } sector_t;

endpackage

// ----- rtl/core/evm_sqrt_cell.sv -----
// One restoring square root step: decides one root bit per cell.
module evm_sqrt_cell import evm_pkg::*; #(
  parameter int RW = 64,
  parameter int NW = 128,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] root_in,
  input  logic [NW-1:0] rem_in,
  output logic [RW-1:0] root_out,
  output logic [NW-1:0] rem_out
);

  logic [NW-1:0] trial;
  logic [RW-1:0] root_nxt;
  logic [NW-1:0] rem_nxt;
  logic [RW-1:0] root_r;
  logic [NW-1:0] rem_r;

  // (r + 2^b)^2 - r^2 = 2^(b+1) r + 2^(2b)
  always_comb begin
    trial = (NW'(root_in) << (BIT + 1)) | (NW'(1) << (2 * BIT));
    if (rem_in >= trial) begin
      rem_nxt  = rem_in - trial;
      root_nxt = root_in | (RW'(1) << BIT);
    end else begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign root_out = root_r;
  assign rem_out  = rem_r;

endmodule

// ----- rtl/core/evm_sqrt.sv -----
// Pipelined integer square root built from a chain of root cells.
module evm_sqrt import evm_pkg::*; #(
  parameter int RW = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0] root
);

  logic [RW-1:0]   root_c [RW+1];
  logic [2*RW-1:0] rem_c  [RW+1];

  assign root_c[0] = '0;
  assign rem_c[0]  = rad;

  for (genvar g = 0; g < RW; g++) begin : g_cell
    evm_sqrt_cell #(.RW(RW), .NW(2*RW), .BIT(RW-1-g)) u_cell (
      .clk(clk), .en(en),
      .root_in(root_c[g]), .rem_in(rem_c[g]),
      .root_out(root_c[g+1]), .rem_out(rem_c[g+1])
    );
  end

  assign root = root_c[RW];

endmodule

// ----- rtl/core/evm_div_cell.sv -----
// One restoring division step with the quotient cap applied each step.
module evm_div_cell import evm_pkg::*; #(
  parameter int NW = 128,
  parameter int DW = 63
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_in,
  input  logic [DW:0]   rem_in,
  input  logic [PctCapW-1:0] q_in,
  input  logic [DW-1:0] d_in,
  output logic [NW-1:0] num_out,
  output logic [DW:0]   rem_out,
  output logic [PctCapW-1:0] q_out,
  output logic [DW-1:0] d_out
);

  localparam logic [PctCapW:0] QCap = (PctCapW+1)'(1) << (PctCapW - 1);

  logic [DW+1:0]    r_sh;
  logic [PctCapW:0] q_sh;
  logic [DW:0]      rem_nxt;
  logic [PctCapW-1:0] q_nxt;
  logic [NW-1:0]    num_r;
  logic [DW:0]      rem_r;
  logic [PctCapW-1:0] q_r;
  logic [DW-1:0]    d_r;

  always_comb begin
    r_sh = {rem_in, num_in[NW-1]};
    q_sh = {q_in, 1'b0};
    if (r_sh >= (DW+2)'(d_in)) begin
      r_sh    = r_sh - (DW+2)'(d_in);
      q_sh[0] = 1'b1;
    end
    rem_nxt = r_sh[DW:0];
    q_nxt   = (q_sh > QCap) ? QCap[PctCapW-1:0] : q_sh[PctCapW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= {num_in[NW-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      d_r   <= d_in;
    end
  end

  assign num_out = num_r;
  assign rem_out = rem_r;
  assign q_out   = q_r;
  assign d_out   = d_r;

endmodule

// ----- rtl/core/evm_cordic_cell.sv -----
// One CORDIC vectoring rotation; carries a side payload along.
module evm_cordic_cell import evm_pkg::*; #(
  parameter int STEP = 0,
  parameter int PW = 8
) (
  input  logic clk,
  input  logic en,
  input  logic signed [CordicW+1:0] x_in,
  input  logic signed [CordicW+1:0] y_in,
  input  logic signed [AngW-1:0]    z_in,
  input  logic [PW-1:0]             p_in,
  output logic signed [CordicW+1:0] x_out,
  output logic signed [CordicW+1:0] y_out,
  output logic signed [AngW-1:0]    z_out,
  output logic [PW-1:0]             p_out
);

  logic signed [CordicW+1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [AngW-1:0]    z_r, z_nxt;
  logic [PW-1:0]             p_r;
  logic signed [AngW-1:0]    t;

  always_comb begin
    t = AngW'(ATAN_TAB[STEP]);
    if (!y_in[CordicW+1]) begin
      x_nxt = x_in + (y_in >>> STEP);
      y_nxt = y_in - (x_in >>> STEP);
      z_nxt = z_in + t;
    end else begin
      x_nxt = x_in - (y_in >>> STEP);
      y_nxt = y_in + (x_in >>> STEP);
      z_nxt = z_in - t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      p_r <= p_in;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign p_out = p_r;

endmodule

// ----- rtl/core/evm_cordic.sv -----
// CORDIC arctangent pipeline: normalize, then a chain of rotation cells.
module evm_cordic import evm_pkg::*; #(
  parameter int AW = 64,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic [PW-1:0] p_in,
  output logic [30:0]   ang,
  output logic [PW-1:0] p_out
);

  localparam int LzW = $clog2(AW + 1);

  // Stage 0: find the leading one of a|b.
  logic [AW-1:0]  m;
  logic [LzW-1:0] msb;
  logic [AW-1:0]  a_r, b_r;
  logic [LzW-1:0] msb_r;
  logic [1:0]     spc_r; // bit0: b zero, bit1: a zero
  logic [PW-1:0]  p0_r;

  always_comb begin
    m   = a | b;
    msb = '0;
    for (int i = 0; i < AW; i++) begin
      if (m[i]) msb = LzW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a;
      b_r   <= b;
      msb_r <= msb;
      spc_r <= {a == '0, b == '0};
      p0_r  <= p_in;
    end
  end

  // Stage 1: shift so the larger value sits in [2^57, 2^58).
  logic [CordicW-1:0] an, bn;
  always_comb begin
    if (int'(msb_r) >= 57) begin
      an = CordicW'(a_r >> (int'(msb_r) - 57));
      bn = CordicW'(b_r >> (int'(msb_r) - 57));
    end else begin
      an = CordicW'(a_r) << (57 - int'(msb_r));
      bn = CordicW'(b_r) << (57 - int'(msb_r));
    end
  end

  logic signed [CordicW+1:0] xc [CordicSteps+1];
  logic signed [CordicW+1:0] yc [CordicSteps+1];
  logic signed [AngW-1:0]    zc [CordicSteps+1];
  logic [PW+1:0]             pc [CordicSteps+1];

  always_ff @(posedge clk) begin
    if (en) begin
      xc[0] <= {2'b00, an};
      yc[0] <= {2'b00, bn};
      zc[0] <= '0;
      pc[0] <= {spc_r, p0_r};
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    evm_cordic_cell #(.STEP(g), .PW(PW+2)) u_cell (
      .clk(clk), .en(en),
      .x_in(xc[g]), .y_in(yc[g]), .z_in(zc[g]), .p_in(pc[g]),
      .x_out(xc[g+1]), .y_out(yc[g+1]), .z_out(zc[g+1]), .p_out(pc[g+1])
    );
  end

  // Output stage: clamp and apply the special cases.
  logic signed [AngW-1:0] zf;
  logic [30:0] ang_nxt, ang_r;
  logic [PW-1:0] pout_r;
  always_comb begin
    zf = zc[CordicSteps];
    if (pc[CordicSteps][PW])        ang_nxt = '0;
    else if (pc[CordicSteps][PW+1]) ang_nxt = 31'h4000_0000;
    else if (zf < 0)                ang_nxt = '0;
    else if (zf > AngW'(32'h4000_0000)) ang_nxt = 31'h4000_0000;
    else                            ang_nxt = zf[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r  <= ang_nxt;
      pout_r <= pc[CordicSteps][PW-1:0];
    end
  end

  assign ang   = ang_r;
  assign p_out = pout_r;

endmodule

// ----- rtl/core/edge_vector_metrics.sv -----
// Top level of the segment metrics pipeline.
// edge_vector_metrics takes one point pair per cycle and delivers one result
// per cycle through a pipeline whose longest path runs as follows. A register
// stage forms the coordinate differences. The horizontal root takes 64 cells,
// and one register follows it. The restoring divider takes 128 cells, and the
// output register follows it. The CORDIC arctangents (35 stages) run beside
// the divider and are delayed to line up with it. The whole pipeline advances
// only when its output register is free or being taken, so out_ready stalls
// every stage together and no result is lost.
module edge_vector_metrics import evm_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_start_z,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_end_z,
  output logic out_valid,
  input  logic out_ready,
  output logic [COORD_BITS:0] out_length_3d,
  output logic [COORD_BITS:0] out_length_horizontal,
  output logic signed [COORD_BITS:0] out_rise,
  output logic [COORD_BITS-1:0] out_gain,
  output logic [19:0] out_slope_angle,
  output logic [31:0] out_slope_pct,
  output logic out_slope_valid,
  output logic [15:0] out_bearing,
  output logic [2:0] out_compass_sector
);

  localparam int HF  = 62 - COORD_BITS;
  localparam int DW  = COORD_BITS + 1;
  localparam int RW  = 64;
  localparam int NW  = 128;
  localparam int SQL = RW;           // root latency
  localparam int CRL = CordicSteps + 3;
  localparam int DVL = NW;
  localparam int TAIL = (DVL > CRL ? DVL : CRL);
  localparam int LAT = 1 + SQL + 1 + TAIL + 1;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // Stage A: differences and magnitudes.
  logic signed [DW-1:0] dx, dy, dz;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  assign dx = DW'(in_end_x) - DW'(in_start_x);
  assign dy = DW'(in_end_y) - DW'(in_start_y);
  assign dz = DW'(in_end_z) - DW'(in_start_z);

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx;
      dy_r <= dy;
      dz_r <= dz;
    end
  end

  logic [COORD_BITS:0] ax, ay, az;
  assign ax = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign ay = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
  assign az = dz_r[DW-1] ? DW'(-dz_r) : DW'(dz_r);

  logic [NW-1:0] s2, t2;
  assign s2 = NW'(ax * ax) + NW'(ay * ay);
  assign t2 = s2 + NW'(az * az);

  // Side data flows alongside the roots.
  localparam int SW = 3 * DW;
  logic [SW-1:0] side [SQL+1];
  assign side[0] = {dx_r, dy_r, dz_r};
  for (genvar g = 0; g < SQL; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side[g+1] <= side[g];
    end
  end

  logic [RW-1:0] hf, l3;
  evm_sqrt #(.RW(RW)) u_sqrt_h (
    .clk(clk), .en(en), .rad(s2 << (2 * HF)), .root(hf));
  evm_sqrt #(.RW(RW)) u_sqrt_3 (
    .clk(clk), .en(en), .rad(t2), .root(l3));

  // Stage B: register roots and recover deltas.
  logic [RW-1:0] hf_r, l3_r;
  logic signed [DW-1:0] bx_r, by_r, bz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      hf_r <= hf;
      l3_r <= l3;
      {bx_r, by_r, bz_r} <= side[SQL];
    end
  end

  logic [COORD_BITS:0] bax, bay, baz;
  assign bax = bx_r[DW-1] ? DW'(-bx_r) : DW'(bx_r);
  assign bay = by_r[DW-1] ? DW'(-by_r) : DW'(by_r);
  assign baz = bz_r[DW-1] ? DW'(-bz_r) : DW'(bz_r);

  // Slope angle CORDIC; bearing CORDIC.
  localparam int PB = DW + 2 * RW;
  logic [PB-1:0] pb_in, pb_out;
  logic [30:0] sang_a, brg_a;
  assign pb_in = {bz_r, hf_r, l3_r};
  evm_cordic #(.AW(RW), .PW(PB)) u_cor_s (
    .clk(clk), .en(en), .a(hf_r), .b(RW'(baz) << HF),
    .p_in(pb_in), .ang(sang_a), .p_out(pb_out));
  logic [1:0] q_dummy;
  evm_cordic #(.AW(RW), .PW(2)) u_cor_b (
    .clk(clk), .en(en), .a(RW'(bay)), .b(RW'(bax)),
    .p_in({bx_r[DW-1], by_r[DW-1]}), .ang(brg_a), .p_out(q_dummy));

  // Divider: (|dz|*1e6*2^F + hf/2) / hf.
  logic [NW-1:0] dnum;
  logic [NW-1:0] mul6;
  assign mul6 = NW'(baz) * NW'(1000000);
  assign dnum = (mul6 << HF) + NW'(hf_r >> 1);

  logic [NW-1:0]      dn [DVL+1];
  logic [63:0]        dr [DVL+1];
  logic [PctCapW-1:0] dq [DVL+1];
  logic [62:0]        dd [DVL+1];
  assign dn[0] = dnum;
  assign dr[0] = '0;
  assign dq[0] = '0;
  assign dd[0] = hf_r[62:0];
  for (genvar g = 0; g < DVL; g++) begin : g_div
    evm_div_cell #(.NW(NW), .DW(63)) u_cell (
      .clk(clk), .en(en),
      .num_in(dn[g]), .rem_in(dr[g]), .q_in(dq[g]), .d_in(dd[g]),
      .num_out(dn[g+1]), .rem_out(dr[g+1]), .q_out(dq[g+1]), .d_out(dd[g+1]));
  end

  // Align the CORDIC outputs with the divider.
  localparam int DLY = TAIL - CRL;
  logic [PB+61:0] ad [DLY+1];
  assign ad[0] = {pb_out, sang_a, brg_a};
  for (genvar g = 0; g < DLY; g++) begin : g_al
    always_ff @(posedge clk) begin
      if (en) ad[g+1] <= ad[g];
    end
  end

  logic [PB-1:0] pf;
  logic [30:0]   sa, ba;
  logic [PctCapW-1:0] qf;
  assign {pf, sa, ba} = ad[DLY];
  assign qf = dq[DVL];

  logic signed [DW-1:0] fz;
  logic [RW-1:0] fhf, fl3;
  assign {fz, fhf, fl3} = pf;

  // Bearing quadrant flags ride the bearing CORDIC payload; realign them.
  logic [1:0] qd [DLY+1];
  assign qd[0] = q_dummy;
  for (genvar g = 0; g < DLY; g++) begin : g_qd
    always_ff @(posedge clk) begin
      if (en) qd[g+1] <= qd[g];
    end
  end

  logic [32:0] brg_raw;
  logic [49:0] brg_m;
  logic [15:0] brg_v;
  logic [63:0] sang_m;
  logic [3:0]  sec_cnt;
  always_comb begin
    case (qd[DLY])
      2'b00:   brg_raw = 33'(ba);
      2'b01:   brg_raw = 33'h0_8000_0000 - 33'(ba);
      2'b11:   brg_raw = 33'h0_8000_0000 + 33'(ba);
      default: brg_raw = (33'h1_0000_0000 - 33'(ba)) & 33'h0_FFFF_FFFF;
    endcase
    brg_m = (50'(brg_raw[31:0]) * 50'd36000 + 50'h8000_0000) >> 32;
    brg_v = (brg_m >= 50'd36000) ? 16'd0 : brg_m[15:0];
    // Each sector boundary sits halfway between compass points; the ninth
    // count (just below a full turn) wraps back to north.
    sec_cnt = '0;
    for (int k = 0; k < 8; k++) begin
      if (brg_v >= 16'(2250 + 4500 * k)) sec_cnt = sec_cnt + 4'd1;
    end
    sang_m = (64'(sa) * 64'd3600000 + 64'h8000_0000) >> 32;
  end

  logic [COORD_BITS:0]        l3_o, lh_o, rise_o;
  logic [COORD_BITS-1:0]      gain_o;
  logic [19:0] sang_o;
  logic [31:0] pct_o;
  logic        sv_o;
  logic [15:0] brg_o;
  logic [2:0]  sec_o;
  always_ff @(posedge clk) begin
    if (en) begin
      l3_o   <= fl3[COORD_BITS:0];
      lh_o   <= DW'(fhf >> HF);
      rise_o <= fz;
      gain_o <= (!fz[DW-1] && fz != '0) ? fz[COORD_BITS-1:0] : '0;
      sv_o   <= fhf != '0;
      sang_o <= (fhf != '0) ? sang_m[19:0] : '0;
      pct_o  <= (fhf == '0) ? '0 :
                (qf > PctCapW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : qf[31:0];
      brg_o  <= brg_v;
      sec_o  <= sec_cnt[2:0];
    end
  end

  assign out_length_3d         = l3_o;
  assign out_length_horizontal = lh_o;
  assign out_rise              = rise_o;
  assign out_gain              = gain_o;
  assign out_slope_angle       = sang_o;
  assign out_slope_pct         = pct_o;
  assign out_slope_valid       = sv_o;
  assign out_bearing           = brg_o;
  assign out_compass_sector    = sec_o;

  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bearing < 16'd36000) else $error("bearing out of range");
  a_slope_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_slope_valid |-> out_slope_pct == '0 && out_slope_angle == '0)
    else $error("slope not zero");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bearing))
    else $error("result lost in stall");

endmodule

// ----- bench/edge_vector_metrics_tb.sv -----
// Self-checking testbench for the segment metrics pipeline, with scoreboard and stimulus.
module edge_vector_metrics_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import evm_pkg::*;

  localparam int CB = CoordBitsDef;
  localparam int HFRAC = 62 - CB;
  localparam int RANDOM_PAIRS = 1250;
  localparam int LONG_HOLD = 600;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic signed [CB-1:0] sx, sy, sz, ex, ey, ez;
  } point_pair_t;

  typedef struct {
    logic [CB:0] len3d;
    logic [CB:0] len_h;
    logic [CB:0] rise;
    logic [CB-1:0] gain;
    logic [19:0] slope_angle;
    logic [31:0] slope_pct;
    logic slope_valid;
    logic [15:0] bearing;
    sector_t sector;
  } metrics_t;

  class metrics_scoreboard;
    metrics_t pending_q[$];
    int errors = 0;

    static function logic [63:0] floor_root(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
    endfunction

    // Binary-angle arctangent of b/a, 2^32 units per turn, clamped to a quarter turn.
    static function logic [63:0] vector_angle(logic [63:0] a, logic [63:0] b);
      logic [63:0] m;
      longint x, y, z, xs, ys;
      if (b == 0) return 64'd0;
      if (a == 0) return 64'd1 << 30;
      m = a | b;
      while (m >= (64'd1 << 58)) begin
        a >>= 1; b >>= 1; m >>= 1;
      end
      while (m < (64'd1 << 57)) begin
        a <<= 1; b <<= 1; m <<= 1;
      end
      x = a;
      y = b;
      z = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
        end else begin
          x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
        end
      end
      if (z < 0) z = 0;
      if (z > (longint'(1) << 30)) z = longint'(1) << 30;
      return z;
    endfunction

    static function metrics_t predict_metrics(point_pair_t p);
      metrics_t e;
      longint dx, dy, dz;
      logic [63:0] ax, ay, az, hf, ang, brg, sang;
      logic [127:0] s, t, num, quot;
      dx = longint'(p.ex) - longint'(p.sx);
      dy = longint'(p.ey) - longint'(p.sy);
      dz = longint'(p.ez) - longint'(p.sz);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      s = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
      t = s + {64'd0, az} * {64'd0, az};
      hf = floor_root(s << (2 * HFRAC));
      e.len3d = (CB+1)'(floor_root(t));
      e.len_h = (CB+1)'(hf >> HFRAC);
      e.rise = (CB+1)'(dz);
      e.gain = (dz > 0) ? CB'(dz) : '0;
      e.slope_angle = '0;
      e.slope_pct = '0;
      e.slope_valid = 1'b0;
      if (hf != 0) begin
        sang = (vector_angle(hf, az << HFRAC) * 64'd3600000 + (64'd1 << 31)) >> 32;
        num = (({64'd0, az} * 128'd1000000) << HFRAC) + {64'd0, hf >> 1};
        quot = num / {64'd0, hf};
        e.slope_angle = sang[19:0];
        e.slope_pct = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
        e.slope_valid = 1'b1;
      end
      ang = vector_angle(ay, ax);
      if (dx >= 0 && dy >= 0) brg = ang;
      else if (dx >= 0) brg = (64'd1 << 31) - ang;
      else if (dy < 0) brg = (64'd1 << 31) + ang;
      else brg = ((64'd1 << 32) - ang) & 64'hFFFF_FFFF;
      brg = (brg * 64'd36000 + (64'd1 << 31)) >> 32;
      // A bearing that rounds up to a full turn wraps to north.
      if (brg >= 36000) brg = 0;
      e.bearing = brg[15:0];
      e.sector = sector_t'(3'(((brg + 2250) / 4500) & 7));
      return e;
    endfunction

    function void note_request(point_pair_t p);
      pending_q.push_back(predict_metrics(p));
    endfunction

    function void check_result(metrics_t got);
      metrics_t e;
      bit bad;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no request outstanding: len3d %0d bearing %0d",
                 $time, got.len3d, got.bearing);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      bad = 1'b0;
      if (got.len3d !== e.len3d) begin
        $display("%0t: length_3d exp %0d got %0d", $time, e.len3d, got.len3d);
        bad = 1'b1;
      end
      if (got.len_h !== e.len_h) begin
        $display("%0t: length_horizontal exp %0d got %0d", $time, e.len_h, got.len_h);
        bad = 1'b1;
      end
      if (got.rise !== e.rise) begin
        $display("%0t: rise exp %h got %h", $time, e.rise, got.rise);
        bad = 1'b1;
      end
      if (got.gain !== e.gain) begin
        $display("%0t: gain exp %0d got %0d", $time, e.gain, got.gain);
        bad = 1'b1;
      end
      if (got.slope_angle !== e.slope_angle) begin
        $display("%0t: slope_angle exp %0d got %0d", $time, e.slope_angle, got.slope_angle);
        bad = 1'b1;
      end
      if (got.slope_pct !== e.slope_pct) begin
        $display("%0t: slope_pct exp %0d got %0d", $time, e.slope_pct, got.slope_pct);
        bad = 1'b1;
      end
      if (got.slope_valid !== e.slope_valid) begin
        $display("%0t: slope_valid exp %b got %b", $time, e.slope_valid, got.slope_valid);
        bad = 1'b1;
      end
      if (got.bearing !== e.bearing) begin
        $display("%0t: bearing exp %0d got %0d", $time, e.bearing, got.bearing);
        bad = 1'b1;
      end
      if (got.sector !== e.sector) begin
        $display("%0t: compass_sector exp %s got %s", $time, e.sector.name(),
                 got.sector.name());
        bad = 1'b1;
      end
      if (bad) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [CB-1:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CB:0] out_length_3d, out_length_horizontal;
  logic signed [CB:0] out_rise;
  logic [CB-1:0] out_gain;
  logic [19:0] out_slope_angle;
  logic [31:0] out_slope_pct;
  logic out_slope_valid;
  logic [15:0] out_bearing;
  logic [2:0] out_compass_sector;

  metrics_scoreboard sb = new();
  point_pair_t directed_q[$];
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  edge_vector_metrics dut (.*);

  always #2 clk = ~clk;

  // Receiver: ready pattern changes mode every stretch; a long hold is timed here.
  initial begin
    int mode, left, hold;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        for (hold = 0; hold < LONG_HOLD; hold++) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
        long_hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= (left % 7) < 5;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    metrics_t got;
    if (rst_n && out_valid && out_ready) begin
      got.len3d = out_length_3d;
      got.len_h = out_length_horizontal;
      got.rise = out_rise;
      got.gain = out_gain;
      got.slope_angle = out_slope_angle;
      got.slope_pct = out_slope_pct;
      got.slope_valid = out_slope_valid;
      got.bearing = out_bearing;
      got.sector = sector_t'(out_compass_sector);
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic point_pair_t pair_of(longint sx, longint sy, longint sz,
                                          longint ex, longint ey, longint ez);
    point_pair_t p;
    p.sx = CB'(sx); p.sy = CB'(sy); p.sz = CB'(sz);
    p.ex = CB'(ex); p.ey = CB'(ey); p.ez = CB'(ez);
    return p;
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t p;
    int d;
    p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
    p.ex = $urandom; p.ey = $urandom; p.ez = $urandom;
    d = int'($urandom_range(0, 2000)) - 1000;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
      end
      3, 4: begin
        p.ex = p.sx + $signed($urandom_range(0, 2000)) - 1000;
        p.ey = p.sy + $signed($urandom_range(0, 2000)) - 1000;
        p.ez = p.sz + d;
      end
      5: begin
        p.ex = p.sx;
        p.ey = p.sy;
      end
      6: begin
        p.ex = p.sx;
        p.ey = p.sy + d;
      end
      7: begin
        p.ey = p.sy;
        p.ex = p.sx + d;
      end
      default: begin
        p.ex = p.sx + $signed($urandom_range(0, 6)) - 3;
        p.ey = p.sy + $signed($urandom_range(0, 6)) - 3;
      end
    endcase
    return p;
  endfunction

  // Offers one request; valid stays high into the next request when chained.
  task automatic send_pair(point_pair_t p);
    in_valid <= 1'b1;
    in_start_x <= p.sx; in_start_y <= p.sy; in_start_z <= p.sz;
    in_end_x <= p.ex; in_end_y <= p.ey; in_end_z <= p.ez;
    do @(posedge clk); while (!in_ready);
    sb.note_request(p);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int burst, sent;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_q.push_back(pair_of(0, 0, 0, 0, 0, 0));
    directed_q.push_back(pair_of(-2147483648, -2147483648, -2147483648,
                                 2147483647, 2147483647, 2147483647));
    directed_q.push_back(pair_of(2147483647, 2147483647, 2147483647,
                                 -2147483648, -2147483648, -2147483648));
    directed_q.push_back(pair_of(7, 7, 0, 7, 7, 5));
    directed_q.push_back(pair_of(7, 7, 0, 7, 7, -5));
    directed_q.push_back(pair_of(0, 0, 0, 0, 100, 0));
    directed_q.push_back(pair_of(0, 0, 0, 100, 0, 0));
    directed_q.push_back(pair_of(0, 0, 0, 0, -100, 0));
    directed_q.push_back(pair_of(0, 0, 0, -100, 0, 0));
    directed_q.push_back(pair_of(0, 0, 0, 1, 1, 1));
    directed_q.push_back(pair_of(0, 0, 0, 1, -1, -1));
    directed_q.push_back(pair_of(0, 0, 0, -1, -1, 3));
    directed_q.push_back(pair_of(0, 0, 0, -1, 1, -3));
    // Barely west of north: the bearing rounds to a full turn and wraps.
    directed_q.push_back(pair_of(0, -2147483648, 0, -1, 2147483647, 0));
    // Steep slopes that saturate the percent field.
    directed_q.push_back(pair_of(0, 0, -2147483648, 1, 0, 2147483647));
    directed_q.push_back(pair_of(0, 0, 2147483647, 0, 1, -2147483648));
    directed_q.push_back(pair_of(0, 0, 0, 1000, 414, 0));
    directed_q.push_back(pair_of(0, 0, 0, 1000, 415, 0));
    directed_q.push_back(pair_of(5, 5, 5, 8, 9, 5));
    directed_q.push_back(pair_of(-2147483648, 0, 0, 2147483647, 0, 1));
    foreach (directed_q[i]) send_pair(directed_q[i]);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      burst = $urandom_range(1, 60);
      for (int k = 0; k < burst && sent < RANDOM_PAIRS; k++) begin
        if (sent == 400) long_hold_req = 1'b1;
        send_pair(random_pair());
        sent++;
      end
      if (sent >= 800 && sent < 800 + burst) wait_drained();
      else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 25));
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
